FILE: rtl/core/tdq_pkg.sv
`timescale 1ns / 1ps
// tdq_pkg: shared types and constants for the TPDF dither quantizer.
// Holds the job beat format, back-end state codes and generator constants.
// No dependencies.
package tdq_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIT_DEPTH     = 2'd0,
		REG_DITHER_ENABLE = 2'd1,
		REG_DITHER_SEED   = 2'd2
	} cfg_reg_t;

	localparam logic [4:0]  BIT_DEPTH_RST     = 5'd16;
	localparam logic        DITHER_ENABLE_RST = 1'b0;
	localparam logic [63:0] DITHER_SEED_RST   = 64'd0;
	localparam logic [4:0]  MIN_DEPTH         = 5'd2;

	// splitmix64 constants
	localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

	// quantizer datapath widths
	localparam int SAMPLE_W = 32;
	localparam int CODE_W   = 24;
	localparam int DRAW_W   = 24;
	localparam int DITH_W   = DRAW_W + 1;
	localparam int NUM_W    = 56;
	localparam int FRAC_W   = 24;

	localparam logic [NUM_W-1:0] ROUND_HALF = NUM_W'(1) << (FRAC_W - 1);

	// depth of the front-to-back job queue
	localparam int JOB_DEPTH = 2;

	// one classified input beat
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       restart;
		logic                       dither;
		logic [4:0]                 depth_m1;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE1,
		ST_ISSUE2,
		ST_WAIT,
		ST_QUANT,
		ST_ABS,
		ST_ROUND
	} back_state_t;

endpackage

FILE: rtl/core/tdq_front.sv
`timescale 1ns / 1ps
// tdq_front: configuration registers and input beat acceptance.
// Classifies each beat (effective depth, dither on/off) into a job_t.
// Depends on tdq_pkg.
module tdq_front #(
	parameter int MAX_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [tdq_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input  logic [tdq_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [tdq_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic                                  restart,
	output logic                                  job_push,
	output tdq_pkg::job_t                         job,
	input  logic                                  job_full,
	output logic [63:0]                           seed
);
	import tdq_pkg::*;

	logic [4:0]  bit_depth_q;
	logic        dither_enable_q;
	logic [63:0] dither_seed_q;
	logic [4:0]  depth_eff;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q     <= BIT_DEPTH_RST;
			dither_enable_q <= DITHER_ENABLE_RST;
			dither_seed_q   <= DITHER_SEED_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_BIT_DEPTH:     bit_depth_q     <= cfg_wdata[4:0];
				REG_DITHER_ENABLE: dither_enable_q <= cfg_wdata[0];
				REG_DITHER_SEED:   dither_seed_q   <= cfg_wdata;
				default:           ;
			endcase
		end
	end

	// clamp depth to the supported range
	always_comb begin
		if (bit_depth_q < MIN_DEPTH)
			depth_eff = MIN_DEPTH;
		else if (bit_depth_q > 5'(MAX_BITS))
			depth_eff = 5'(MAX_BITS);
		else
			depth_eff = bit_depth_q;
	end

	// classify and forward the beat
	assign full          = job_full;
	assign job_push      = push && !job_full;
	assign job.sample    = sample_in;
	assign job.restart   = restart;
	assign job.dither    = dither_enable_q;
	assign job.depth_m1  = depth_eff - 5'd1;
	assign seed          = dither_seed_q;

endmodule

FILE: rtl/core/tdq_queue.sv
`timescale 1ns / 1ps
// tdq_queue: small flop-based queue of job beats between front and back.
// Depends on tdq_pkg.
module tdq_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tdq_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output tdq_pkg::job_t dout,
	output logic          empty
);
	import tdq_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: rtl/core/tdq_mix.sv
`timescale 1ns / 1ps
// tdq_mix: five-stage pipelined splitmix64 output mixer, one draw per cycle.
// 64-bit constant products are split into three 32x32 partial products.
// Depends on tdq_pkg.
module tdq_mix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [63:0]                 in_state,
	output logic                        out_valid,
	output logic [tdq_pkg::DRAW_W-1:0]  out_draw
);
	import tdq_pkg::*;

	logic [4:0]  vld_q;
	logic [63:0] z_s1;
	logic [63:0] pll_s2, pll_s4;
	logic [31:0] phl_s2, plh_s2, phl_s4, plh_s4;
	logic [63:0] z_s3;
	logic [63:0] w_s5;
	logic [63:0] y_sum, w_sum, w_fin;
	logic [63:0] ahl_full, alh_full, bhl_full, blh_full;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[3:0], in_valid};
	end

	// cross partial products, low halves only
	assign ahl_full = z_s1[63:32] * MIX_MUL_A[31:0];
	assign alh_full = z_s1[31:0] * MIX_MUL_A[63:32];
	assign bhl_full = z_s3[63:32] * MIX_MUL_B[31:0];
	assign blh_full = z_s3[31:0] * MIX_MUL_B[63:32];

	assign y_sum = pll_s2 + {phl_s2 + plh_s2, 32'd0};
	assign w_sum = pll_s4 + {phl_s4 + plh_s4, 32'd0};

	// datapath stages
	always_ff @(posedge clk) begin
		z_s1   <= in_state ^ (in_state >> 30);
		pll_s2 <= z_s1[31:0] * MIX_MUL_A[31:0];
		phl_s2 <= ahl_full[31:0];
		plh_s2 <= alh_full[31:0];
		z_s3   <= y_sum ^ (y_sum >> 27);
		pll_s4 <= z_s3[31:0] * MIX_MUL_B[31:0];
		phl_s4 <= bhl_full[31:0];
		plh_s4 <= blh_full[31:0];
		w_s5   <= w_sum;
	end

	assign w_fin     = w_s5 ^ (w_s5 >> 31);
	assign out_draw  = w_fin[63:64-DRAW_W];
	assign out_valid = vld_q[4];

endmodule

FILE: rtl/core/tdq_back.sv
`timescale 1ns / 1ps
// tdq_back: generator state, dither draws, rounding, clamping and result register.
// Depends on tdq_pkg and tdq_mix.
module tdq_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_valid,
	input  tdq_pkg::job_t                       job,
	output logic                                job_pop,
	input  logic [63:0]                         seed,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [tdq_pkg::SAMPLE_W-1:0] sample_out,
	output logic signed [tdq_pkg::CODE_W-1:0]   level_code,
	output logic                                clipped
);
	import tdq_pkg::*;

	back_state_t state_q, state_d;

	job_t                     job_q;
	logic [63:0]              rng_state_q;
	logic [63:0]              rng_next;
	logic                     issue;
	logic                     out_load;
	logic                     mix_valid;
	logic [DRAW_W-1:0]        mix_draw;
	logic [DRAW_W-1:0]        u1_q, u2_q;
	logic                     got_one_q;
	logic signed [DITH_W-1:0] dith;
	logic signed [NUM_W-1:0]  num_d;
	logic signed [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]         mag_q;
	logic                     neg_q;
	logic [NUM_W-1:0]         rnd_full;
	logic [31:0]              rnd;
	logic [31:0]              lim;
	logic                     clip;
	logic [31:0]              code32;
	logic                     out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic signed [CODE_W-1:0]   level_code_q;
	logic                       clipped_q;

	assign rng_next = rng_state_q + GOLDEN_INC;

	tdq_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (issue),
		.in_state  (rng_next),
		.out_valid (mix_valid),
		.out_draw  (mix_draw)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and controls
	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = job.dither ? ST_ISSUE1 : ST_QUANT;
				end
			end
			ST_ISSUE1: begin
				issue   = 1'b1;
				state_d = ST_ISSUE2;
			end
			ST_ISSUE2: begin
				issue   = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (mix_valid && got_one_q)
					state_d = ST_QUANT;
			end
			ST_QUANT: state_d = ST_ABS;
			ST_ABS:   state_d = ST_ROUND;
			ST_ROUND: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// generator state and draw capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_state_q <= '0;
			got_one_q   <= 1'b0;
		end else begin
			if (job_pop && job.restart)
				rng_state_q <= seed;
			else if (issue)
				rng_state_q <= rng_next;
			if (job_pop)
				got_one_q <= 1'b0;
			else if (mix_valid)
				got_one_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop)
			job_q <= job;
		if (mix_valid && !got_one_q)
			u1_q <= mix_draw;
		if (mix_valid && got_one_q)
			u2_q <= mix_draw;
	end

	// scale by 2^(depth-1) and add dither
	assign dith  = job_q.dither ? (DITH_W'({1'b0, u1_q}) - DITH_W'({1'b0, u2_q}))
	                            : '0;
	assign num_d = (NUM_W'(job_q.sample) <<< job_q.depth_m1) + NUM_W'(dith);

	// round half away from zero on the magnitude, then clamp
	assign rnd_full = mag_q + ROUND_HALF;
	assign rnd      = rnd_full[NUM_W-1:FRAC_W];
	assign lim      = 32'd1 << job_q.depth_m1;
	assign clip     = neg_q ? (rnd > lim) : (rnd >= lim);

	always_comb begin
		if (clip)
			code32 = neg_q ? (32'd0 - lim) : (lim - 32'd1);
		else
			code32 = neg_q ? (32'd0 - rnd) : rnd;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_QUANT)
			num_q <= num_d;
		if (state_q == ST_ABS) begin
			neg_q <= num_q[NUM_W-1];
			mag_q <= num_q[NUM_W-1] ? (NUM_W'(0) - NUM_W'(num_q)) : NUM_W'(num_q);
		end
		if (out_load) begin
			level_code_q <= code32[CODE_W-1:0];
			sample_out_q <= code32 << (5'd24 - job_q.depth_m1);
			clipped_q    <= clip;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	assign empty      = !out_valid_q;
	assign sample_out = sample_out_q;
	assign level_code = level_code_q;
	assign clipped    = clipped_q;

	// checks
	a_mix_latency: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> ##5 mix_valid)
		else $error("draw did not leave the mixer after five cycles");

	a_draw_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid |-> (state_q == ST_WAIT))
		else $error("draw arrived outside the wait state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || pop))
		else $error("result register overwritten before it was taken");

	a_rng_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!job_pop && !issue) |=> $stable(rng_state_q))
		else $error("generator state moved without a draw or restart");

endmodule

FILE: rtl/core/tpdf_dither_quantizer_top.sv
`timescale 1ns / 1ps
// Each beat passes the back-end states idle, quant, abs and round, with issue1, issue2
// and wait between idle and quant when dither is on. The back-end sequencer handles
// one sample at a time and waits on the 5-stage splitmix mixer.
// A 2-entry job queue lets the input side keep accepting while a result waits.
// Reset (arst_n low, asynchronous) empties queue and result register, sets
// bit_depth 16, dither off, seed 0 and generator state 0.
module tpdf_dither_quantizer_top #(
	parameter int MAX_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [tdq_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input  logic [tdq_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [tdq_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic                                  restart,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [tdq_pkg::SAMPLE_W-1:0]   sample_out,
	output logic signed [tdq_pkg::CODE_W-1:0]     level_code,
	output logic                                  clipped
);
	import tdq_pkg::*;

	logic        job_push;
	logic        job_full;
	logic        job_empty;
	logic        job_pop;
	job_t        job_in;
	job_t        job_out;
	logic [63:0] seed;

	tdq_front #(
		.MAX_BITS (MAX_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.sample_in (sample_in),
		.restart   (restart),
		.job_push  (job_push),
		.job       (job_in),
		.job_full  (job_full),
		.seed      (seed)
	);

	tdq_queue #(
		.DEPTH (JOB_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	tdq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (!job_empty),
		.job        (job_out),
		.job_pop    (job_pop),
		.seed       (seed),
		.empty      (empty),
		.pop        (pop),
		.sample_out (sample_out),
		.level_code (level_code),
		.clipped    (clipped)
	);

endmodule
